// File: sv/i2r_pkg.sv
`timescale 1ns / 1ps

package i2r_pkg;

    localparam int VAL_W     = 12;
    localparam int SYM_W     = 7;
    localparam int TOK_W     = 4;
    localparam int TOK_COUNT = 13;

    localparam logic [VAL_W-1:0] VALUE_MAX = 12'd3999;
    localparam logic [SYM_W-1:0] SYM_NONE  = 7'd0;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ERR    = 4'b0010,
        S_STEP   = 4'b0100,
        S_SECOND = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic emit_first;
        logic emit_second;
        logic emit_err;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic ge;
        logic two;
        logic fin_first;
        logic fin_second;
        logic out_free;
    } stat_t;

    function automatic logic [VAL_W-1:0] tok_weight(input logic [TOK_W-1:0] idx);
        logic [VAL_W-1:0] w;
        unique case (idx)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            4'd12:   w = 12'd1;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [SYM_W-1:0] tok_first(input logic [TOK_W-1:0] idx);
        logic [SYM_W-1:0] c;
        unique case (idx)
            4'd0:    c = 7'h4D;
            4'd1:    c = 7'h43;
            4'd2:    c = 7'h44;
            4'd3:    c = 7'h43;
            4'd4:    c = 7'h43;
            4'd5:    c = 7'h58;
            4'd6:    c = 7'h4C;
            4'd7:    c = 7'h58;
            4'd8:    c = 7'h58;
            4'd9:    c = 7'h49;
            4'd10:   c = 7'h56;
            4'd11:   c = 7'h49;
            4'd12:   c = 7'h49;
            default: c = 7'h49;
        endcase
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] tok_second(input logic [TOK_W-1:0] idx);
        logic [SYM_W-1:0] c;
        unique case (idx)
            4'd1:    c = 7'h4D;
            4'd3:    c = 7'h44;
            4'd5:    c = 7'h43;
            4'd7:    c = 7'h4C;
            4'd9:    c = 7'h58;
            4'd11:   c = 7'h56;
            default: c = SYM_NONE;
        endcase
        return c;
    endfunction

endpackage

// File: sv/i2r_ctrl.sv
`timescale 1ns / 1ps

module i2r_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  i2r_pkg::stat_t stat,
    output i2r_pkg::cmd_t  cmd
);
    import i2r_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_bad ? S_ERR : S_STEP;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (!stat.ge)
                begin
                    cmd.advance = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    if (stat.two)
                    begin
                        state_next = S_SECOND;
                    end
                    else if (stat.fin_first)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SECOND:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_second = 1'b1;
                    state_next      = stat.fin_second ? S_IDLE : S_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/i2r_datapath.sv
`timescale 1ns / 1ps

module i2r_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [i2r_pkg::VAL_W-1:0] value,
    input  i2r_pkg::cmd_t             cmd,
    output i2r_pkg::stat_t            stat,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [i2r_pkg::SYM_W-1:0] symbol,
    output logic                      last,
    output logic                      error
);
    import i2r_pkg::*;

    logic [VAL_W-1:0] rest_reg;
    logic [VAL_W-1:0] rest_next;
    logic [TOK_W-1:0] tok_reg;
    logic [TOK_W-1:0] tok_next;
    logic             valid_reg;
    logic             valid_next;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic             last_reg;
    logic             last_next;
    logic             err_reg;
    logic             err_next;

    logic [VAL_W-1:0] weight;
    logic [SYM_W-1:0] second;

    assign weight = tok_weight(tok_reg);
    assign second = tok_second(tok_reg);

    assign stat.in_bad     = (value == '0) || (value > VALUE_MAX);
    assign stat.ge         = (rest_reg >= weight);
    assign stat.two        = (second != SYM_NONE);
    assign stat.fin_first  = (second == SYM_NONE) && (rest_reg == weight);
    assign stat.fin_second = (rest_reg == '0);
    assign stat.out_free   = !valid_reg || m_tready;

    always_comb
    begin
        rest_next  = rest_reg;
        tok_next   = tok_reg;
        valid_next = valid_reg && !m_tready;
        sym_next   = sym_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (cmd.load)
        begin
            rest_next = value;
            tok_next  = '0;
        end
        if (cmd.advance)
        begin
            tok_next = tok_reg + 4'd1;
        end
        if (cmd.emit_first)
        begin
            rest_next  = rest_reg - weight;
            valid_next = 1'b1;
            sym_next   = tok_first(tok_reg);
            last_next  = stat.fin_first;
            err_next   = 1'b0;
        end
        if (cmd.emit_second)
        begin
            valid_next = 1'b1;
            sym_next   = second;
            last_next  = stat.fin_second;
            err_next   = 1'b0;
        end
        if (cmd.emit_err)
        begin
            valid_next = 1'b1;
            sym_next   = SYM_NONE;
            last_next  = 1'b1;
            err_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        tok_reg  <= tok_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = valid_reg;
    assign symbol   = sym_reg;
    assign last     = last_reg;
    assign error    = err_reg;

endmodule

// File: sv/integer_to_roman_numeral.sv
`timescale 1ns / 1ps

// Converts one 12-bit unsigned value per input transaction into its Roman
// numeral, sent as one ASCII letter per output transaction with tlast on the
// final letter. Values outside 1 to 3999 give a single transaction with
// tuser set, tlast set and character code 0. One value is converted at a
// time: the controller walks the 13-entry token table one entry per cycle
// while the entry's weight exceeds the remainder, and emits one letter per
// cycle while the output register is free. The next value is taken while the
// final letter still waits in the output register.

module integer_to_roman_numeral (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] symbol, [7] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] error
);
    import i2r_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [SYM_W-1:0] symbol;

    i2r_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2r_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (s_tdata[VAL_W-1:0]),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .symbol   (symbol),
        .last     (m_tlast),
        .error    (m_tuser)
    );

    assign m_tdata = {1'b0, symbol};

    a_idle_between_items: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tlast))
        else $error("input taken while a numeral is still being sent");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("error transaction not a single zero character");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_first || cmd.emit_second || cmd.emit_err) |-> stat.out_free)
        else $error("output register overwritten");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second value accepted before conversion");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import i2r_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             error;
    } numeral_char_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             typed;
        logic [SYM_W-1:0] symbol;
        logic             error;
    } stim_row_t;

    localparam logic [SYM_W-1:0] CH_I = 7'h49;
    localparam logic [SYM_W-1:0] CH_V = 7'h56;
    localparam logic [SYM_W-1:0] CH_X = 7'h58;
    localparam logic [SYM_W-1:0] CH_L = 7'h4C;
    localparam logic [SYM_W-1:0] CH_C = 7'h43;
    localparam logic [SYM_W-1:0] CH_D = 7'h44;
    localparam logic [SYM_W-1:0] CH_M = 7'h4D;

    localparam logic [VAL_W-1:0] NUMERAL_WEIGHT [TOK_COUNT] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam logic [SYM_W-1:0] NUMERAL_LEAD [TOK_COUNT] = '{
        CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
    };
    localparam logic [SYM_W-1:0] NUMERAL_TRAIL [TOK_COUNT] = '{
        SYM_NONE, CH_M, SYM_NONE, CH_D, SYM_NONE, CH_C, SYM_NONE, CH_L,
        SYM_NONE, CH_X, SYM_NONE, CH_V, SYM_NONE
    };

    localparam int DIRECTED_COUNT = 25;
    localparam int RANDOM_COUNT   = 295;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{12'd0,    1'b1, SYM_NONE, 1'b1},
        '{12'd4000, 1'b1, SYM_NONE, 1'b1},
        '{12'd4001, 1'b1, SYM_NONE, 1'b1},
        '{12'hFFF,  1'b1, SYM_NONE, 1'b1},
        '{12'd1,    1'b1, CH_I,     1'b0},
        '{12'd5,    1'b1, CH_V,     1'b0},
        '{12'd10,   1'b1, CH_X,     1'b0},
        '{12'd50,   1'b1, CH_L,     1'b0},
        '{12'd100,  1'b1, CH_C,     1'b0},
        '{12'd500,  1'b1, CH_D,     1'b0},
        '{12'd1000, 1'b1, CH_M,     1'b0},
        '{12'd3999, 1'b0, SYM_NONE, 1'b0},
        '{12'd3888, 1'b0, SYM_NONE, 1'b0},
        '{12'd4,    1'b0, SYM_NONE, 1'b0},
        '{12'd9,    1'b0, SYM_NONE, 1'b0},
        '{12'd40,   1'b0, SYM_NONE, 1'b0},
        '{12'd90,   1'b0, SYM_NONE, 1'b0},
        '{12'd400,  1'b0, SYM_NONE, 1'b0},
        '{12'd900,  1'b0, SYM_NONE, 1'b0},
        '{12'd2048, 1'b0, SYM_NONE, 1'b0},
        '{12'd2730, 1'b0, SYM_NONE, 1'b0},
        '{12'd1365, 1'b0, SYM_NONE, 1'b0},
        '{12'd1994, 1'b0, SYM_NONE, 1'b0},
        '{12'd3,    1'b0, SYM_NONE, 1'b0},
        '{12'd3998, 1'b0, SYM_NONE, 1'b0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    numeral_char_t roman_q[$];
    int            error_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    integer_to_roman_numeral i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic predict_numeral(input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0] rest;
        numeral_char_t    ch;
        rest = value;
        if (rest == '0 || rest > VALUE_MAX)
        begin
            ch = '{SYM_NONE, 1'b1, 1'b1};
            roman_q.push_back(ch);
            return;
        end
        for (int t = 0; t < TOK_COUNT; t++)
        begin
            while (rest >= NUMERAL_WEIGHT[t])
            begin
                rest -= NUMERAL_WEIGHT[t];
                ch = '{NUMERAL_LEAD[t], 1'b0, 1'b0};
                roman_q.push_back(ch);
                if (NUMERAL_TRAIL[t] != SYM_NONE)
                begin
                    ch = '{NUMERAL_TRAIL[t], 1'b0, 1'b0};
                    roman_q.push_back(ch);
                end
            end
        end
        roman_q[roman_q.size() - 1].last = 1'b1;
    endtask

    // return once the transaction has been accepted
    task automatic send_value(input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            return VAL_W'($urandom_range(3999, 1));
        else if (sel < 90)
            return VAL_W'($urandom_range(4095, 4000));
        else if (sel < 93)
            return '0;
        else
            return VAL_W'($urandom_range(4095, 0));
    endfunction

    always @(posedge clk)
    begin : check_output
        numeral_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (roman_q.size() == 0)
            begin
                $error("unexpected transaction: symbol %h last %b error %b",
                       m_tdata[SYM_W-1:0], m_tlast, m_tuser);
                error_count++;
            end
            else
            begin
                want = roman_q.pop_front();
                if (m_tdata[SYM_W-1:0] !== want.symbol)
                begin
                    $error("symbol: expected %h, got %h", want.symbol, m_tdata[SYM_W-1:0]);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== want.error)
                begin
                    $error("error: expected %b, got %b", want.error, m_tuser);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        numeral_char_t    ch;
        logic [VAL_W-1:0] value;
        int               phase;
        int               guard;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_value(DIRECTED_ROWS[i].value);
            if (DIRECTED_ROWS[i].typed)
            begin
                ch = '{DIRECTED_ROWS[i].symbol, 1'b1, DIRECTED_ROWS[i].error};
                roman_q.push_back(ch);
            end
            else
                predict_numeral(DIRECTED_ROWS[i].value);
        end

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            phase = (i / 40) % 4;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            value = pick_value();
            send_value(value);
            predict_numeral(value);
        end
        s_tvalid <= 1'b0;

        // drain
        while (roman_q.size() != 0)
            @(posedge clk);
        guard = 0;
        while (guard < 60)
        begin
            @(posedge clk);
            guard++;
        end

        if (error_count == 0 && roman_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
